// ===== src/assert_macros.svh =====
// assertion helper macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition");

// antecedent at an edge implies consequent at the same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

// ===== src/tapi_pkg.sv =====
// shared types, widths and constants of the tangent angle path integrator
`default_nettype none
package tapi_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int STEP_W  = 24;
  localparam int POS_W   = 35;
  localparam int TRIG_W  = 16;
  localparam int SUM_W   = 26;
  localparam int TERM_W  = 28;
  localparam int PROD_W  = STEP_W + 1 + TERM_W;

  // cordic datapath
  localparam int CORDIC_STEPS = 16;
  localparam int Z_W  = 32;
  localparam int XY_W = 33;
  localparam logic signed [Z_W-1:0]  PI_Q28      = 32'sd843314857;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [TRIG_W-1:0] ONE_Q14   = 16'sd16384;

  // queue between front and back
  localparam int QDEPTH = 32;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register map
  localparam logic REG_STEP_LENGTH = 1'b0;

  // one classified request handed from front to back
  typedef struct packed {
    logic                     first;
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } item_t;

  // queue status seen by the back end and the top level
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // arctangent table, round(atan(2^-i) * 2^28)
  function automatic logic signed [Z_W-1:0] atan_q28(input int i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:       v = 32'sd210828714;
      1:       v = 32'sd124459457;
      2:       v = 32'sd65760959;
      3:       v = 32'sd33381290;
      4:       v = 32'sd16755422;
      5:       v = 32'sd8385879;
      6:       v = 32'sd4193963;
      7:       v = 32'sd2097109;
      8:       v = 32'sd1048571;
      9:       v = 32'sd524287;
      10:      v = 32'sd262144;
      11:      v = 32'sd131072;
      12:      v = 32'sd65536;
      13:      v = 32'sd32768;
      14:      v = 32'sd16384;
      15:      v = 32'sd8192;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/tapi_front.sv =====
// front end: request intake, credit control and pipelined cordic cos/sin
`default_nettype none
module tapi_front import tapi_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [ANGLE_W-1:0] angle,
  input  wire logic                      first,
  input  wire logic                      pop,
  output logic                           push,
  output item_t                          push_item
);

  logic [QCNT_W-1:0] credit_cnt;
  logic              accept;

  logic                  vld_p   [0:CORDIC_STEPS];
  logic                  flip_p  [0:CORDIC_STEPS];
  logic                  first_p [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_p [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] x_p [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_p [0:CORDIC_STEPS];

  logic signed [Z_W-1:0] z_raw;
  logic signed [Z_W-1:0] z_red;
  logic                  flip;

  logic signed [XY_W:0]     x_rnd, y_rnd;
  logic signed [17:0]       x_q, y_q, x_cl, y_cl, x_sg, y_sg;
  logic                     post_vld;
  item_t                    post_item;

  // credits cover every request between intake and the queue head
  assign in_stall = (credit_cnt == QCNT_W'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_cnt <= '0;
    end else begin
      credit_cnt <= credit_cnt + QCNT_W'(accept) - QCNT_W'(pop);
    end
  end

  // angle to q.28 and fold into [-pi/2, pi/2]
  always_comb begin
    z_raw = {{(Z_W-ANGLE_W-15){angle[ANGLE_W-1]}}, angle, 15'b0};
    flip  = 1'b0;
    z_red = z_raw;
    if (z_raw > HALF_PI_Q28) begin
      z_red = z_raw - PI_Q28;
      flip  = 1'b1;
    end else if (z_raw < -HALF_PI_Q28) begin
      z_red = z_raw + PI_Q28;
      flip  = 1'b1;
    end
  end

  // valid bits of the cordic pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) begin
        vld_p[k] <= 1'b0;
      end
      post_vld <= 1'b0;
    end else begin
      vld_p[0] <= accept;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        vld_p[k] <= vld_p[k-1];
      end
      post_vld <= vld_p[CORDIC_STEPS];
    end
  end

  // cordic rotation stages, one micro-rotation each
  always_ff @(posedge clk) begin
    z_p[0]     <= z_red;
    x_p[0]     <= GAIN_Q30;
    y_p[0]     <= '0;
    flip_p[0]  <= flip;
    first_p[0] <= first;
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      flip_p[k]  <= flip_p[k-1];
      first_p[k] <= first_p[k-1];
      if (!z_p[k-1][Z_W-1]) begin
        x_p[k] <= x_p[k-1] - (y_p[k-1] >>> (k-1));
        y_p[k] <= y_p[k-1] + (x_p[k-1] >>> (k-1));
        z_p[k] <= z_p[k-1] - atan_q28(k-1);
      end else begin
        x_p[k] <= x_p[k-1] + (y_p[k-1] >>> (k-1));
        y_p[k] <= y_p[k-1] - (x_p[k-1] >>> (k-1));
        z_p[k] <= z_p[k-1] + atan_q28(k-1);
      end
    end
  end

  // round to q.14, clamp to unit range, undo the fold
  always_comb begin
    x_rnd = {x_p[CORDIC_STEPS][XY_W-1], x_p[CORDIC_STEPS]} + 34'sd32768;
    y_rnd = {y_p[CORDIC_STEPS][XY_W-1], y_p[CORDIC_STEPS]} + 34'sd32768;
    x_q   = x_rnd[XY_W:16];
    y_q   = y_rnd[XY_W:16];
    x_cl  = (x_q > 18'sd16384) ? 18'sd16384 : ((x_q < -18'sd16384) ? -18'sd16384 : x_q);
    y_cl  = (y_q > 18'sd16384) ? 18'sd16384 : ((y_q < -18'sd16384) ? -18'sd16384 : y_q);
    x_sg  = flip_p[CORDIC_STEPS] ? -x_cl : x_cl;
    y_sg  = flip_p[CORDIC_STEPS] ? -y_cl : y_cl;
  end

  always_ff @(posedge clk) begin
    post_item.first <= first_p[CORDIC_STEPS];
    post_item.c     <= x_sg[TRIG_W-1:0];
    post_item.s     <= y_sg[TRIG_W-1:0];
  end

  assign push      = post_vld;
  assign push_item = post_item;

endmodule
`default_nettype wire

// ===== src/tapi_queue.sv =====
// request queue between the cordic front end and the accumulating back end
`default_nettype none
module tapi_queue import tapi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_status_t  status
);

  item_t             mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] cnt;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  assign head         = mem[rptr];
  assign status.empty = (cnt == '0);
  assign status.full  = (cnt == QCNT_W'(QDEPTH));

endmodule
`default_nettype wire

// ===== src/tapi_back.sv =====
// back end: running sums, step scaling, rounding and saturation, output register
`default_nettype none
module tapi_back import tapi_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [STEP_W-1:0]       step_length,
  input  item_t                        head,
  input  q_status_t                    status,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [POS_W-1:0]      x_pos,
  output logic signed [POS_W-1:0]      y_pos
);

  logic adv;
  logic s1_vld, s2_vld;

  logic signed [SUM_W-1:0]  cos_sum, sin_sum;
  logic signed [SUM_W-1:0]  base_c, base_s;
  logic signed [SUM_W:0]    add_c, add_s;
  logic signed [SUM_W-1:0]  cos_sum_next, sin_sum_next;
  logic signed [TERM_W-1:0] term_x, term_y;
  logic signed [TERM_W-1:0] s1_tx, s1_ty;
  logic signed [PROD_W-1:0] s2_px, s2_py;
  logic signed [PROD_W:0]   rnd_x, rnd_y;
  logic signed [PROD_W-15:0] sh_x, sh_y;
  logic signed [POS_W-1:0]  sat_x, sat_y;

  // whole back pipeline moves when the output slot frees up
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !status.empty;

  // sums seen by this request, then the updated sums
  always_comb begin
    base_c = head.first ? '0 : cos_sum;
    base_s = head.first ? '0 : sin_sum;
    term_x = TERM_W'(ONE_Q14) + TERM_W'(head.c) + TERM_W'($signed({base_c, 1'b0}));
    term_y = TERM_W'(head.s) + TERM_W'($signed({base_s, 1'b0}));
    add_c  = (SUM_W+1)'(base_c) + (SUM_W+1)'(head.c);
    add_s  = (SUM_W+1)'(base_s) + (SUM_W+1)'(head.s);
    if (add_c[SUM_W] != add_c[SUM_W-1]) begin
      cos_sum_next = add_c[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      cos_sum_next = add_c[SUM_W-1:0];
    end
    if (add_s[SUM_W] != add_s[SUM_W-1]) begin
      sin_sum_next = add_s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sin_sum_next = add_s[SUM_W-1:0];
    end
  end

  // round half up to q.16 and saturate to the output range
  always_comb begin
    rnd_x = (PROD_W+1)'(s2_px) + (PROD_W+1)'(16384);
    rnd_y = (PROD_W+1)'(s2_py) + (PROD_W+1)'(16384);
    sh_x  = rnd_x[PROD_W:15];
    sh_y  = rnd_y[PROD_W:15];
    if (sh_x[PROD_W-15:POS_W-1] != '0 && sh_x[PROD_W-15:POS_W-1] != '1) begin
      sat_x = sh_x[PROD_W-15] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_x = sh_x[POS_W-1:0];
    end
    if (sh_y[PROD_W-15:POS_W-1] != '0 && sh_y[PROD_W-15:POS_W-1] != '1) begin
      sat_y = sh_y[PROD_W-15] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_y = sh_y[POS_W-1:0];
    end
  end

  // control: running sums and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_sum   <= '0;
      sin_sum   <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld    <= pop;
      s2_vld    <= s1_vld;
      out_valid <= s2_vld;
      if (pop) begin
        cos_sum <= cos_sum_next;
        sin_sum <= sin_sum_next;
      end
    end
  end

  // datapath: terms, products, results
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tx <= term_x;
      s1_ty <= term_y;
      s2_px <= $signed({1'b0, step_length}) * s1_tx;
      s2_py <= $signed({1'b0, step_length}) * s1_ty;
      x_pos <= sat_x;
      y_pos <= sat_y;
    end
  end

endmodule
`default_nettype wire

// ===== src/tangent_angle_path_integrator_core.sv =====
// top level of the tangent angle path integrator with its register port
// throughput: one request per cycle while intake is not stalled, set by the
// 16-stage cordic pipeline and one-step sums
// intake stalls only when the 32-entry queue credit is used up by a stalled output
// reset (rst, synchronous): clears sums, pipelines and queue; step_length returns to 1.0 mm
`default_nettype none
`include "assert_macros.svh"
module tangent_angle_path_integrator_core import tapi_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [ANGLE_W-1:0] angle,
  input  wire logic                      first,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [POS_W-1:0]        x_pos,
  output logic signed [POS_W-1:0]        y_pos,
  // register port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [STEP_W-1:0] step_length;
  logic              push;
  logic              pop;
  item_t             push_item;
  item_t             head;
  q_status_t         status;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_W'(65536);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP_LENGTH) begin
      step_length <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STEP_LENGTH) begin
      prdata = {{(32-STEP_W){1'b0}}, step_length};
    end
  end

  // front end
  tapi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .angle     (angle),
    .first     (first),
    .pop       (pop),
    .push      (push),
    .push_item (push_item)
  );

  // queue
  tapi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  // back end
  tapi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .step_length (step_length),
    .head        (head),
    .status      (status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_pos       (x_pos),
    .y_pos       (y_pos)
  );

  // credit scheme keeps the queue from overflowing
  `ASSERT_NEVER(a_no_overflow, clk, rst, push && status.full && !pop)
  // back end never reads an empty queue
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !status.empty)
  // a request refused at intake means the queue path holds work
  `ASSERT_IMPLIES(a_stall_has_work, clk, rst, in_stall, !status.empty || push || $past(in_valid))

endmodule
`default_nettype wire
